/* src/tct_pkg.sv */
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types, register indexes and helpers for the centroid tracker.
// ----------------------------------------------------------------------------
package tct_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_DARK_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_FRAME_COLUMNS  = 2'd1;
    localparam logic [1:0] REG_FRAME_ROWS     = 2'd2;

    // Register and port widths
    localparam int THRESH_W  = 9;
    localparam int FSIZE_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;
    localparam int PIXEL_W   = 8;
    localparam int CENTER_W  = 10;
    localparam int DELTA_W   = 11;
    localparam int QCOUNT_W  = 21;

    // Internal frame size width, large enough for the biggest legal frame limit
    localparam int SIZE_W = 13;

    // Reset values of the configuration registers
    localparam logic [THRESH_W-1:0] THRESH_RST = 9'd128;
    localparam logic [FSIZE_W-1:0]  COLS_RST   = 11'd160;
    localparam logic [FSIZE_W-1:0]  ROWS_RST   = 11'd120;

    // Occupancy flags of a queue
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Frame size as used: zero reads as one, large values saturate at the limit
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [FSIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] limit);
        logic [SIZE_W-1:0] ext;
        ext = SIZE_W'(v);
        if (ext == '0)
            return SIZE_W'(1);
        else if (ext > limit)
            return limit;
        else
            return ext;
    endfunction

endpackage

/* src/threshold_centroid_tracker.sv */
// ----------------------------------------------------------------------------
// threshold_centroid_tracker
// Dark-blob centroid and frame-to-frame motion from a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock while full is low. Each frame's column sum,
// row sum and dark-pixel count go into a two-entry queue; the back end divides
// both sums by the count with a restoring divider that produces one quotient
// bit per cycle, and the divider takes up a new frame only once it has
// finished the last one and handed its result to the output word. Full rises
// when two frames' totals are waiting behind the divider, either because frames
// arrive faster than the divider finishes them or because results are not
// being popped. Results are held in an output word until popped; the divider
// starts on the next frame as soon as it is idle.
module threshold_centroid_tracker import tct_pkg::*; #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      write_enable,
    input  logic [CFG_IDX_W-1:0]      write_index,
    input  logic [CFG_DAT_W-1:0]      write_data,
    input  logic                      push,
    output logic                      full,
    input  logic [PIXEL_W-1:0]        pixel_value,
    output logic                      empty,
    input  logic                      pop,
    output logic [CENTER_W-1:0]       center_x,
    output logic [CENTER_W-1:0]       center_y,
    output logic signed [DELTA_W-1:0] delta_x,
    output logic signed [DELTA_W-1:0] delta_y,
    output logic [QCOUNT_W-1:0]       qualifying_count
);

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CNTW  = $clog2(MAX_COLUMNS*MAX_ROWS+1);
    localparam int CSUMW = CNTW + CW;
    localparam int RSUMW = CNTW + RW;
    localparam int QDW   = CSUMW + RSUMW + CNTW;

    logic               accept;
    logic               frame_done;
    logic [CSUMW-1:0]   f_col_sum, b_col_sum;
    logic [RSUMW-1:0]   f_row_sum, b_row_sum;
    logic [CNTW-1:0]    f_count, b_count;
    logic [QDW-1:0]     q_rd_data;
    logic               q_pop;
    queue_status_t      q_status;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;
    assign {b_col_sum, b_row_sum, b_count} = q_rd_data;

    tct_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .accept       (accept),
        .pixel_value  (pixel_value),
        .frame_done   (frame_done),
        .col_sum      (f_col_sum),
        .row_sum      (f_row_sum),
        .pix_count    (f_count)
    );

    tct_fifo #(
        .WIDTH (QDW)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (frame_done),
        .wr_data ({f_col_sum, f_row_sum, f_count}),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    tct_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_status         (q_status),
        .col_sum          (b_col_sum),
        .row_sum          (b_row_sum),
        .pix_count        (b_count),
        .q_pop            (q_pop),
        .pop              (pop),
        .empty            (empty),
        .center_x         (center_x),
        .center_y         (center_y),
        .delta_x          (delta_x),
        .delta_y          (delta_y),
        .qualifying_count (qualifying_count)
    );

endmodule

/* src/tct_front.sv */
// ----------------------------------------------------------------------------
// tct_front
// Pixel front end: configuration registers, raster position tracking and
// per-frame accumulation of column sum, row sum and dark-pixel count.
// ----------------------------------------------------------------------------
module tct_front import tct_pkg::*; #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  write_enable,
    input  logic [CFG_IDX_W-1:0]  write_index,
    input  logic [CFG_DAT_W-1:0]  write_data,
    input  logic                  accept,
    input  logic [PIXEL_W-1:0]    pixel_value,
    output logic                  frame_done,
    output logic [($clog2(MAX_COLUMNS*MAX_ROWS+1)+$clog2(MAX_COLUMNS))-1:0] col_sum,
    output logic [($clog2(MAX_COLUMNS*MAX_ROWS+1)+$clog2(MAX_ROWS))-1:0]    row_sum,
    output logic [$clog2(MAX_COLUMNS*MAX_ROWS+1)-1:0]                        pix_count
);

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CNTW  = $clog2(MAX_COLUMNS*MAX_ROWS+1);
    localparam int CSUMW = CNTW + CW;
    localparam int RSUMW = CNTW + RW;
    localparam logic [SIZE_W-1:0] COL_LIMIT = SIZE_W'(MAX_COLUMNS);
    localparam logic [SIZE_W-1:0] ROW_LIMIT = SIZE_W'(MAX_ROWS);

    logic [THRESH_W-1:0] thresh_reg;
    logic [FSIZE_W-1:0]  cols_cfg_reg;
    logic [FSIZE_W-1:0]  rows_cfg_reg;
    logic [CW-1:0]       col_pos_reg, col_pos_next;
    logic [RW-1:0]       row_pos_reg, row_pos_next;
    logic [CSUMW-1:0]    csum_reg;
    logic [RSUMW-1:0]    rsum_reg;
    logic [CNTW-1:0]     cnt_reg;
    logic [SIZE_W-1:0]   cols, rows;
    logic                dark, col_last, row_last;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg   <= THRESH_RST;
            cols_cfg_reg <= COLS_RST;
            rows_cfg_reg <= ROWS_RST;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                REG_DARK_THRESHOLD: thresh_reg   <= write_data[THRESH_W-1:0];
                REG_FRAME_COLUMNS:  cols_cfg_reg <= write_data[FSIZE_W-1:0];
                REG_FRAME_ROWS:     rows_cfg_reg <= write_data[FSIZE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Dark test, position, end-of-row / end-of-frame detection and next running sums
    always_comb
    begin
        cols     = clamp_size(cols_cfg_reg, COL_LIMIT);
        rows     = clamp_size(rows_cfg_reg, ROW_LIMIT);
        dark     = {1'b0, pixel_value} < thresh_reg;
        col_last = (SIZE_W'(col_pos_reg) + SIZE_W'(1)) >= cols;
        row_last = (SIZE_W'(row_pos_reg) + SIZE_W'(1)) >= rows;
        col_pos_next = col_last ? '0 : col_pos_reg + CW'(1);
        row_pos_next = row_pos_reg;
        if (col_last)
            row_pos_next = row_last ? '0 : row_pos_reg + RW'(1);
        frame_done = accept && col_last && row_last;
        col_sum    = csum_reg + (dark ? CSUMW'(col_pos_reg) : '0);
        row_sum    = rsum_reg + (dark ? RSUMW'(row_pos_reg) : '0);
        pix_count  = cnt_reg + (dark ? CNTW'(1) : '0);
    end

    // Running sums, cleared once a frame's totals go to the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            csum_reg    <= '0;
            rsum_reg    <= '0;
            cnt_reg     <= '0;
        end
        else if (accept)
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            if (frame_done)
            begin
                csum_reg <= '0;
                rsum_reg <= '0;
                cnt_reg  <= '0;
            end
            else
            begin
                csum_reg <= col_sum;
                rsum_reg <= row_sum;
                cnt_reg  <= pix_count;
            end
        end
    end

endmodule

/* src/tct_fifo.sv */
// ----------------------------------------------------------------------------
// tct_fifo
// Two-entry queue carrying frame totals from the front end to the divider.
// ----------------------------------------------------------------------------
module tct_fifo import tct_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output queue_status_t    status
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;

    assign status.full  = fill_reg == 2'd2;
    assign status.empty = fill_reg == 2'd0;
    assign rd_data      = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (wr_en && !rd_en)
                fill_reg <= fill_reg + 2'd1;
            else if (rd_en && !wr_en)
                fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule

/* src/tct_back.sv */
// ----------------------------------------------------------------------------
// tct_back
// Result back end: bit-serial division of both sums by the count, delta
// against the previous centroid, and the result word register.
// ----------------------------------------------------------------------------
module tct_back import tct_pkg::*; #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  queue_status_t       q_status,
    input  logic [($clog2(MAX_COLUMNS*MAX_ROWS+1)+$clog2(MAX_COLUMNS))-1:0] col_sum,
    input  logic [($clog2(MAX_COLUMNS*MAX_ROWS+1)+$clog2(MAX_ROWS))-1:0]    row_sum,
    input  logic [$clog2(MAX_COLUMNS*MAX_ROWS+1)-1:0]                        pix_count,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output logic [CENTER_W-1:0] center_x,
    output logic [CENTER_W-1:0] center_y,
    output logic signed [DELTA_W-1:0] delta_x,
    output logic signed [DELTA_W-1:0] delta_y,
    output logic [QCOUNT_W-1:0] qualifying_count
);

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CNTW  = $clog2(MAX_COLUMNS*MAX_ROWS+1);
    localparam int QW    = (CW > RW) ? CW : RW;
    localparam int NUMW  = CNTW + QW;
    localparam int CNTXW = (CNTW > QCOUNT_W) ? CNTW : QCOUNT_W;
    localparam int STPW  = $clog2(QW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [STPW-1:0]     step_reg;
    logic [CNTW-1:0]     den_reg;
    logic [CNTW-1:0]     xrem_reg, yrem_reg, xrem_next, yrem_next;
    logic [QW-1:0]       xq_reg, yq_reg, xq_next, yq_next;
    logic [NUMW-1:0]     xnum, ynum;
    logic [CNTW:0]       xtrial, ytrial;
    logic                xge, yge;
    logic [CENTER_W-1:0] cx, cy;
    logic [CENTER_W-1:0] prev_x_reg, prev_y_reg;
    logic                out_valid_reg;
    logic                out_free;

    assign xnum     = NUMW'(col_sum);
    assign ynum     = NUMW'(row_sum);
    assign out_free = !out_valid_reg || pop;
    assign q_pop    = (state_reg == ST_IDLE) && !q_status.empty;
    assign empty    = !out_valid_reg;

    // One restoring division step per cycle on each sum
    always_comb
    begin
        xtrial    = {xrem_reg, xq_reg[QW-1]};
        ytrial    = {yrem_reg, yq_reg[QW-1]};
        xge       = xtrial >= {1'b0, den_reg};
        yge       = ytrial >= {1'b0, den_reg};
        xrem_next = xge ? CNTW'(xtrial - {1'b0, den_reg}) : xtrial[CNTW-1:0];
        yrem_next = yge ? CNTW'(ytrial - {1'b0, den_reg}) : ytrial[CNTW-1:0];
        xq_next   = (xq_reg << 1) | QW'(xge);
        yq_next   = (yq_reg << 1) | QW'(yge);
    end

    // Centroid, forced to zero for a frame with no dark pixel
    always_comb
    begin
        if (den_reg == '0)
        begin
            cx = '0;
            cy = '0;
        end
        else
        begin
            cx = CENTER_W'(xq_reg);
            cy = CENTER_W'(yq_reg);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!q_status.empty) state_next = ST_DIV;
            ST_DIV:  if (step_reg == STPW'(QW - 1)) state_next = ST_WAIT;
            ST_WAIT: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DIV)
                step_reg <= step_reg + STPW'(1);
            else
                step_reg <= '0;
        end
    end

    // Divider datapath
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            den_reg  <= pix_count;
            xrem_reg <= xnum[NUMW-1:QW];
            yrem_reg <= ynum[NUMW-1:QW];
            xq_reg   <= xnum[QW-1:0];
            yq_reg   <= ynum[QW-1:0];
        end
        else if (state_reg == ST_DIV)
        begin
            xrem_reg <= xrem_next;
            yrem_reg <= yrem_next;
            xq_reg   <= xq_next;
            yq_reg   <= yq_next;
        end
    end

    // Result word and previous centroid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
        end
        else
        begin
            if (state_reg == ST_WAIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                prev_x_reg    <= cx;
                prev_y_reg    <= cy;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WAIT && out_free)
        begin
            center_x         <= cx;
            center_y         <= cy;
            delta_x          <= DELTA_W'({1'b0, cx} - {1'b0, prev_x_reg});
            delta_y          <= DELTA_W'({1'b0, cy} - {1'b0, prev_y_reg});
            qualifying_count <= QCOUNT_W'(CNTXW'(den_reg));
        end
    end

endmodule
